### rtl/core/nta_pkg.sv
// Shared types and constants for the neighbor table with aging.
// Used by neighbor_table_with_aging. No dependencies.
package nta_pkg;

  // Table geometry
  localparam int TABLE_ENTRIES = 32;
  localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int SCAN_W = IDX_W + 1;
  localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);

  // Field widths
  localparam int OP_W      = 2;
  localparam int CALL_W    = 56;
  localparam int RSSI_W    = 9;
  localparam int TICK_W    = 32;
  localparam int SLOT_W    = 5;
  localparam int STATUS_W  = 3;
  localparam int OUT_CNT_W = 6;

  localparam logic [TICK_W-1:0] TIMEOUT_RESET = 32'd6000;

  // Opcodes (bit 1 set decodes as a read)
  localparam logic [OP_W-1:0] OP_UPDATE = 2'd0;
  localparam logic [OP_W-1:0] OP_SWEEP  = 2'd1;
  localparam logic [OP_W-1:0] OP_READ   = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_REFRESHED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_INSERTED   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DROPPED    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_SWEEP_DONE = 3'd3;
  localparam logic [STATUS_W-1:0] ST_READ_DONE  = 3'd4;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // One stored neighbor entry
  typedef struct packed {
    logic [CALL_W-1:0] call;
    logic [RSSI_W-1:0] rssi;
    logic [TICK_W-1:0] seen_at;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

### rtl/core/nta_entry_ram.sv
// Single-port-write, single-port-read synchronous RAM for neighbor entries.
// Read data is registered, so it appears in the cycle after raddr is presented. No dependencies.
module nta_entry_ram #(
  parameter int  WIDTH = 97,
  parameter int  DEPTH = 32,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/neighbor_table_with_aging.sv
// Top level of the neighbor table with timeout aging.
// Depends on nta_pkg and nta_entry_ram.
//
// Update and sweep: the scan reads every entry, one entry-RAM read per cycle,
// then S_FINISH registers the result and strobes out_valid.
// Read: S_READ, then S_READ_OUT. One item at a time; busy is high until the result strobe.
// Results are strobed for one cycle; the receiver cannot stall them.
// Reset (rst_n, synchronous) clears all live bits and the live count, and sets
// timeout_ticks to 6000; entry contents are undefined until written.
module neighbor_table_with_aging (
  input  logic                           clk,
  input  logic                           rst_n,
  // command
  input  logic                           start,
  output logic                           busy,
  input  logic [nta_pkg::OP_W-1:0]       in_opcode,
  input  logic [nta_pkg::CALL_W-1:0]     in_call_sign,
  input  logic signed [nta_pkg::RSSI_W-1:0] in_rssi_dbm,
  input  logic [nta_pkg::TICK_W-1:0]     in_now_ticks,
  input  logic [nta_pkg::SLOT_W-1:0]     in_slot,
  // result
  output logic                           out_valid,
  output logic [nta_pkg::STATUS_W-1:0]   out_status,
  output logic [nta_pkg::SLOT_W-1:0]     out_slot_index,
  output logic [nta_pkg::OUT_CNT_W-1:0]  out_live_count,
  output logic [nta_pkg::OUT_CNT_W-1:0]  out_removed_count,
  output logic                           out_entry_valid,
  output logic [nta_pkg::CALL_W-1:0]     out_entry_call,
  output logic signed [nta_pkg::RSSI_W-1:0] out_entry_rssi,
  // configuration
  input  logic                           cfg_we,
  input  logic [nta_pkg::TICK_W-1:0]     cfg_wdata
);

  import nta_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH,
    S_READ,
    S_READ_OUT
  } state_t;

  localparam idx_t LAST_IDX = idx_t'(TABLE_ENTRIES - 1);

  state_t              state_r;
  logic [TICK_W-1:0]   timeout_r;
  logic [TABLE_ENTRIES-1:0] live_r;
  cnt_t                live_cnt_r;
  cnt_t                removed_r;

  // latched command
  logic [OP_W-1:0]     op_r;
  logic [CALL_W-1:0]   call_r;
  logic [RSSI_W-1:0]   rssi_r;
  logic [TICK_W-1:0]   now_r;
  logic [SLOT_W-1:0]   slot_r;

  // scan pipeline
  logic [SCAN_W-1:0]   scan_r;
  logic                chk_vld_r;
  idx_t                chk_idx_r;
  logic                hit_r;
  idx_t                hit_idx_r;
  logic                free_r;
  idx_t                free_idx_r;

  // registered outputs
  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [SLOT_W-1:0]   out_slot_r;
  logic [OUT_CNT_W-1:0] out_live_r;
  logic [OUT_CNT_W-1:0] out_removed_r;
  logic                out_ev_r;
  logic [CALL_W-1:0]   out_call_r;
  logic [RSSI_W-1:0]   out_rssi_r;

  // RAM interface
  logic                mem_we;
  idx_t                mem_waddr;
  entry_t              mem_wdata;
  idx_t                mem_raddr;
  entry_t              mem_rdata;

  // derived
  logic                scan_issue;
  logic                chk_live;
  logic                chk_match;
  logic                chk_aged;
  logic [TICK_W-1:0]   chk_age;
  logic [SLOT_W+IDX_W-1:0] slot_ext;
  idx_t                slot_idx;
  logic                slot_in_range;
  logic                slot_live;

  // Widen or trim a table index to the result slot field
  function automatic logic [SLOT_W-1:0] idx_to_slot(input idx_t i);
    logic [SLOT_W+IDX_W-1:0] w;
    w = {{SLOT_W{1'b0}}, i};
    return w[SLOT_W-1:0];
  endfunction

  // Widen or trim an entry count to the result count field
  function automatic logic [OUT_CNT_W-1:0] cnt_to_out(input cnt_t c);
    logic [OUT_CNT_W+CNT_W-1:0] w;
    w = {{OUT_CNT_W{1'b0}}, c};
    return w[OUT_CNT_W-1:0];
  endfunction

  // Entry storage
  nta_entry_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_entry_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Slot decode for reads
  assign slot_ext      = {{IDX_W{1'b0}}, slot_r};
  assign slot_idx      = slot_ext[IDX_W-1:0];
  assign slot_in_range = slot_ext < (SLOT_W+IDX_W)'(TABLE_ENTRIES);
  assign slot_live     = slot_in_range && live_r[slot_idx];

  // Scan read issue and check of the returning entry
  assign scan_issue = scan_r < SCAN_W'(TABLE_ENTRIES);
  assign mem_raddr  = (state_r == S_READ) ? slot_idx : scan_r[IDX_W-1:0];
  assign chk_live   = live_r[chk_idx_r];
  assign chk_match  = chk_live && (mem_rdata.call == call_r);
  assign chk_age    = now_r - mem_rdata.seen_at;
  assign chk_aged   = chk_live && (chk_age > timeout_r);

  // Write back on refresh or insert; no read is in flight then
  assign mem_we          = (state_r == S_FINISH) && (op_r == OP_UPDATE) && (hit_r || free_r);
  assign mem_waddr       = hit_r ? hit_idx_r : free_idx_r;
  assign mem_wdata.call    = call_r;
  assign mem_wdata.rssi    = rssi_r;
  assign mem_wdata.seen_at = now_r;

  // Latch the command on transfer
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      op_r   <= in_opcode;
      call_r <= in_call_sign;
      rssi_r <= in_rssi_dbm;
      now_r  <= in_now_ticks;
      slot_r <= in_slot;
    end
  end

  // Sequencer, live bits and registered results
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      timeout_r   <= TIMEOUT_RESET;
      live_r      <= '0;
      live_cnt_r  <= '0;
      removed_r   <= '0;
      scan_r      <= '0;
      chk_vld_r   <= 1'b0;
      hit_r       <= 1'b0;
      free_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      chk_vld_r   <= 1'b0;
      if (cfg_we) begin
        timeout_r <= cfg_wdata;
      end
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            scan_r    <= '0;
            hit_r     <= 1'b0;
            free_r    <= 1'b0;
            removed_r <= '0;
            // opcode with bit 1 set is a read
            if (in_opcode[1]) begin
              state_r <= S_READ;
            end else begin
              state_r <= S_SCAN;
            end
          end
        end

        S_SCAN: begin
          // advance the read pointer
          if (scan_issue) begin
            scan_r    <= scan_r + 1'b1;
            chk_vld_r <= 1'b1;
            chk_idx_r <= scan_r[IDX_W-1:0];
          end
          // check the entry that just came back
          if (chk_vld_r) begin
            if (op_r == OP_SWEEP) begin
              if (chk_aged) begin
                live_r[chk_idx_r] <= 1'b0;
                live_cnt_r        <= live_cnt_r - 1'b1;
                removed_r         <= removed_r + 1'b1;
              end
            end else begin
              if (chk_match && !hit_r) begin
                hit_r     <= 1'b1;
                hit_idx_r <= chk_idx_r;
              end
              if (!chk_live && !free_r) begin
                free_r     <= 1'b1;
                free_idx_r <= chk_idx_r;
              end
            end
            if (chk_idx_r == LAST_IDX) begin
              state_r <= S_FINISH;
            end
          end
        end

        S_FINISH: begin
          out_valid_r   <= 1'b1;
          out_ev_r      <= 1'b0;
          out_call_r    <= '0;
          out_rssi_r    <= '0;
          out_removed_r <= '0;
          out_slot_r    <= '0;
          out_live_r    <= cnt_to_out(live_cnt_r);
          state_r       <= S_IDLE;
          if (op_r == OP_SWEEP) begin
            out_status_r  <= ST_SWEEP_DONE;
            out_removed_r <= cnt_to_out(removed_r);
          end else begin
            // a live match wins over a free slot
            priority if (hit_r) begin
              out_status_r <= ST_REFRESHED;
              out_slot_r   <= idx_to_slot(hit_idx_r);
            end else if (free_r) begin
              live_r[free_idx_r] <= 1'b1;
              live_cnt_r   <= live_cnt_r + 1'b1;
              out_status_r <= ST_INSERTED;
              out_slot_r   <= idx_to_slot(free_idx_r);
              out_live_r   <= cnt_to_out(live_cnt_r + 1'b1);
            end else begin
              out_status_r <= ST_DROPPED;
            end
          end
        end

        S_READ: begin
          // RAM read in flight
          state_r <= S_READ_OUT;
        end

        S_READ_OUT: begin
          out_valid_r   <= 1'b1;
          out_status_r  <= ST_READ_DONE;
          out_slot_r    <= slot_r;
          out_live_r    <= cnt_to_out(live_cnt_r);
          out_removed_r <= '0;
          out_ev_r      <= slot_live;
          out_call_r    <= slot_live ? mem_rdata.call : '0;
          out_rssi_r    <= slot_live ? mem_rdata.rssi : '0;
          state_r       <= S_IDLE;
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign busy              = (state_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_slot_index    = out_slot_r;
  assign out_live_count    = out_live_r;
  assign out_removed_count = out_removed_r;
  assign out_entry_valid   = out_ev_r;
  assign out_entry_call    = out_call_r;
  assign out_entry_rssi    = out_rssi_r;

endmodule
